### design/kct_pkg.sv
// Package with the shared widths, codes and types of the keyed count table.
`default_nettype none

package kct_pkg;

    localparam int KEY_W   = 32;
    localparam int CNT_W   = 32;
    localparam int OP_W    = 2;
    localparam int ST_W    = 3;
    localparam int ENTRY_W = KEY_W + CNT_W;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
    localparam logic [ST_W-1:0] ST_DUP     = 3'd2;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;

    // Outputs of the shared compare and saturating add unit.
    typedef struct packed {
        logic             eq;
        logic [CNT_W-1:0] sum;
    } t_alu_res;

endpackage

`default_nettype wire

### design/kct_mem.sv
// Entry memory of the keyed count table: one write port, one registered read port.
`default_nettype none

module kct_mem
    import kct_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [ENTRY_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr,
    output      logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/kct_alu.sv
// Shared unit of the keyed count table: equality compare and 32-bit signed saturating add.
`default_nettype none

module kct_alu
    import kct_pkg::*;
(
    input  wire logic [CNT_W-1:0] i_a,
    input  wire logic [CNT_W-1:0] i_b,
    output      t_alu_res         o_res
);

    logic [CNT_W:0] sum_ext;

    assign sum_ext = {i_a[CNT_W-1], i_a} + {i_b[CNT_W-1], i_b};

    always_comb begin
        o_res.eq = (i_a == i_b);
        // The two top bits differ only when the signed sum left the 32-bit range.
        if (sum_ext[CNT_W] != sum_ext[CNT_W-1]) begin
            o_res.sum = sum_ext[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}}
                                       : {1'b0, {(CNT_W-1){1'b1}}};
        end else begin
            o_res.sum = sum_ext[CNT_W-1:0];
        end
    end

endmodule

`default_nettype wire

### design/keyed_count_table.sv
// Top level of the keyed count table: request sequencer, entry memory and shared unit.
//
// Requests arrive on the s_axis channel: tuser carries the opcode (insert, lookup,
// update, list) and tdata carries the key and the amount. Results leave on the
// m_axis channel: tuser carries the status, tdata the key and the count, and tlast
// marks the final result of a request. The block takes one request at a time and
// holds s_axis_tready low while it works on it.
// Lookup, update and insert scan the stored keys one per cycle through a single
// registered memory read port and stop at the first matching key; a result may
// then wait for the receiver. Insert into a full table and list of an empty table
// skip the scan. List reads one entry at a time: S_LRD reads it and S_LEMIT
// presents it, waiting for the output register, before the next entry is read.
// Results go through an output register, so the next request is taken while a
// finished result still waits; a stalled receiver holds the result and, once a
// second result is ready, the sequencer waits for the register to drain.
// Reset empties the table at once by clearing the entry count; the memory itself
// is not cleared because only entries below the count are ever read.
`default_nettype none

module keyed_count_table
    import kct_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Request channel.
    input  wire logic               s_axis_tvalid,
    output      logic               s_axis_tready,
    // tdata fields from bit 0 up: part_key [31:0], amount [63:32].
    input  wire logic [ENTRY_W-1:0] s_axis_tdata,
    // tuser fields from bit 0 up: opcode [1:0].
    input  wire logic [OP_W-1:0]    s_axis_tuser,
    // Result channel.
    output      logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // tdata fields from bit 0 up: out_key [31:0], out_count [63:32].
    output      logic [ENTRY_W-1:0] m_axis_tdata,
    // tuser fields from bit 0 up: status [2:0].
    output      logic [ST_W-1:0]    m_axis_tuser,
    // last_result.
    output      logic               m_axis_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_INS,
        S_EMIT,
        S_LRD,
        S_LEMIT
    } t_state;

    t_state             r_state;
    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [CNT_W-1:0]   r_amt;
    logic [CW-1:0]      r_total;
    logic [CW-1:0]      r_rd;
    logic               r_dv;
    logic [AW-1:0]      r_didx;
    logic [AW-1:0]      r_hidx;
    logic [CNT_W-1:0]   r_hcnt;
    logic [ST_W-1:0]    r_res_st;
    logic [KEY_W-1:0]   r_res_key;
    logic [CNT_W-1:0]   r_res_cnt;
    logic               r_ovalid;
    logic [ENTRY_W-1:0] r_otdata;
    logic [ST_W-1:0]    r_ouser;
    logic               r_olast;

    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic               scan_issue;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ENTRY_W-1:0] mem_q;
    logic [KEY_W-1:0]   q_key;
    logic [CNT_W-1:0]   q_cnt;
    logic [CNT_W-1:0]   alu_a;
    logic [CNT_W-1:0]   alu_b;
    t_alu_res           alu_res;
    logic               list_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    // A finished result enters the output register whenever the register can take it.
    assign out_load      = out_free && ((r_state == S_EMIT) || (r_state == S_LEMIT));

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otdata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    // Entries are stored as {count, key}, matching the result tdata layout.
    assign q_key = mem_q[KEY_W-1:0];
    assign q_cnt = mem_q[ENTRY_W-1:KEY_W];

    // The scan issues one read per cycle while stored entries remain.
    assign scan_issue = (r_state == S_SCAN) && (r_rd < r_total);
    assign mem_re     = scan_issue || (r_state == S_LRD);

    // A new entry goes in at the end of the table; an update writes back in place.
    assign mem_we    = (r_state == S_INS) || ((r_state == S_HIT) && (r_op == OP_UPDATE));
    assign mem_waddr = (r_state == S_INS) ? r_total[AW-1:0] : r_hidx;
    assign mem_wdata = (r_state == S_INS) ? {r_amt, r_key} : {alu_res.sum, r_key};

    // The shared unit compares keys during the scan and adds counts afterward.
    assign alu_a = (r_state == S_SCAN) ? q_key : r_hcnt;
    assign alu_b = (r_state == S_SCAN) ? r_key : r_amt;

    assign list_last = ((r_rd + CW'(1)) == r_total);

    kct_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (mem_q)
    );

    kct_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_rd     <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // The output register fills with a new result, or drains when the
            // receiver takes the transfer and nothing new arrives.
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op  <= s_axis_tuser;
                        r_key <= s_axis_tdata[KEY_W-1:0];
                        r_amt <= s_axis_tdata[ENTRY_W-1:KEY_W];
                        r_rd  <= '0;
                        r_dv  <= 1'b0;
                        if (s_axis_tuser == OP_LIST) begin
                            if (r_total == '0) begin
                                r_res_st  <= ST_EMPTY;
                                r_res_key <= '0;
                                r_res_cnt <= '0;
                                r_state   <= S_EMIT;
                            end else begin
                                r_state <= S_LRD;
                            end
                        end else if ((s_axis_tuser == OP_INSERT) &&
                                     (r_total >= CW'(DEPTH))) begin
                            // Fullness wins over a duplicate key.
                            r_res_st  <= ST_FULL;
                            r_res_key <= s_axis_tdata[KEY_W-1:0];
                            r_res_cnt <= '0;
                            r_state   <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (scan_issue) begin
                        r_rd <= r_rd + CW'(1);
                    end
                    r_dv   <= scan_issue;
                    r_didx <= r_rd[AW-1:0];
                    if (r_dv && alu_res.eq) begin
                        r_hcnt  <= q_cnt;
                        r_hidx  <= r_didx;
                        r_state <= S_HIT;
                    end else if (!r_dv && (r_rd >= r_total)) begin
                        // Every stored key was compared without a match.
                        if (r_op == OP_INSERT) begin
                            r_state <= S_INS;
                        end else begin
                            r_res_st  <= ST_MISSING;
                            r_res_key <= r_key;
                            r_res_cnt <= '0;
                            r_state   <= S_EMIT;
                        end
                    end
                end

                S_HIT: begin
                    r_res_key <= r_key;
                    if (r_op == OP_INSERT) begin
                        r_res_st  <= ST_DUP;
                        r_res_cnt <= r_hcnt;
                    end else if (r_op == OP_UPDATE) begin
                        r_res_st  <= ST_OK;
                        r_res_cnt <= alu_res.sum;
                    end else begin
                        r_res_st  <= ST_OK;
                        r_res_cnt <= r_hcnt;
                    end
                    r_state <= S_EMIT;
                end

                S_INS: begin
                    r_total   <= r_total + CW'(1);
                    r_res_st  <= ST_OK;
                    r_res_key <= r_key;
                    r_res_cnt <= r_amt;
                    r_state   <= S_EMIT;
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_otdata <= {r_res_cnt, r_res_key};
                        r_ouser  <= r_res_st;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end

                S_LRD: begin
                    r_state <= S_LEMIT;
                end

                S_LEMIT: begin
                    // The read data holds until the next read, so a stall is safe.
                    if (out_free) begin
                        r_otdata <= mem_q;
                        r_ouser  <= ST_OK;
                        r_olast  <= list_last;
                        r_rd     <= r_rd + CW'(1);
                        r_state  <= list_last ? S_IDLE : S_LRD;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The entry count never passes the table depth.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(DEPTH))
        else $error("entry count exceeds table depth");

    // An insert grows the table by exactly one entry.
    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |=> (r_total == $past(r_total) + CW'(1)))
        else $error("insert did not advance the entry count");

    // The scan only reads entries that were written.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_re && (r_state == S_SCAN)) |-> (r_rd < r_total))
        else $error("scan read beyond stored entries");

    // An empty-list result is always the final one of its request.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |-> m_axis_tlast)
        else $error("empty-list result without last flag");

    // A list entry is read before it is presented.
    a_list_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LRD) |=> (r_state == S_LEMIT))
        else $error("list read not followed by its result");

endmodule

`default_nettype wire
